// File: rtl/core/bpwf_pkg.sv
// Shared types, codes and defaults for the bootloader page-write framer.
package bpwf_pkg;

    localparam int DEFAULT_PAGE_BYTES  = 256;
    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam int SIZE_W   = 21;
    localparam int ADDR_W   = 32;
    localparam int CMD_W    = 16;
    localparam int OFFS_W   = 9;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] RESET_IMAGE_SIZE    = 21'd32768;
    localparam logic [ADDR_W-1:0] RESET_START_ADDRESS = 32'd0;
    localparam logic [CMD_W-1:0]  RESET_WRITE_COMMAND = 16'd0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_COMMAND = 2'd2;

    // Byte roles on the output.
    localparam logic [2:0] ROLE_CMD   = 3'd0;
    localparam logic [2:0] ROLE_ADDR  = 3'd1;
    localparam logic [2:0] ROLE_LEN   = 3'd2;
    localparam logic [2:0] ROLE_DATA  = 3'd3;
    localparam logic [2:0] ROLE_CHECK = 3'd4;

    // Beat positions within one item's output run.
    localparam logic [3:0] BEAT_CMD_HI  = 4'd0;
    localparam logic [3:0] BEAT_CMD_LO  = 4'd1;
    localparam logic [3:0] BEAT_ADDR_3  = 4'd2;
    localparam logic [3:0] BEAT_ADDR_2  = 4'd3;
    localparam logic [3:0] BEAT_ADDR_1  = 4'd4;
    localparam logic [3:0] BEAT_ADDR_0  = 4'd5;
    localparam logic [3:0] BEAT_ADDR_CK = 4'd6;
    localparam logic [3:0] BEAT_LEN     = 4'd7;
    localparam logic [3:0] BEAT_DATA    = 4'd8;
    localparam logic [3:0] BEAT_CHECK   = 4'd9;

    typedef struct packed {
        logic [SIZE_W-1:0] image_size;
        logic [ADDR_W-1:0] start_address;
        logic [CMD_W-1:0]  write_command;
    } t_cfg;

    // One classified image byte, waiting to be serialized.
    typedef struct packed {
        logic              open;
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        len_less_one;
        logic [7:0]        data;
        logic              close;
        logic [7:0]        check;
        logic              image_end;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: rtl/core/bpwf_front.sv
// Front end: accepts image bytes, tracks page state and builds descriptors.
module bpwf_front #(
    parameter int PAGE_BYTES = bpwf_pkg::DEFAULT_PAGE_BYTES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpwf_pkg::t_cfg  i_cfg,
    input  logic            i_accept,
    input  logic [7:0]      i_image_byte,
    output logic            o_push,
    output bpwf_pkg::t_desc o_desc
);
    import bpwf_pkg::*;

    localparam logic [SIZE_W-1:0] PAGE_LEN = SIZE_W'(PAGE_BYTES);

    logic [SIZE_W-1:0] r_image_offset, n_image_offset;
    logic [OFFS_W-1:0] r_page_offset, n_page_offset;
    logic [7:0]        r_len_less_one, n_len_less_one;
    logic [ADDR_W-1:0] r_page_address, n_page_address;
    logic [7:0]        r_check, n_check;

    logic              open, ignore, close;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] remaining, len;
    logic [7:0]        cur_len;
    logic [7:0]        check_base;

    always_comb begin
        open      = (r_page_offset == '0);
        ignore    = open && (r_image_offset >= i_cfg.image_size);
        addr      = (open && r_image_offset == '0) ? i_cfg.start_address : r_page_address;
        remaining = i_cfg.image_size - r_image_offset;
        len       = (remaining > PAGE_LEN) ? PAGE_LEN : remaining;
        cur_len   = open ? 8'(len - SIZE_W'(1)) : r_len_less_one;
        close     = (r_page_offset >= {1'b0, cur_len});
        check_base = open ? cur_len : r_check;

        n_image_offset = r_image_offset + SIZE_W'(1);
        n_len_less_one = cur_len;
        n_check        = check_base ^ i_image_byte;
        n_page_address = close ? (addr + ADDR_W'(cur_len) + ADDR_W'(1)) : addr;
        n_page_offset  = close ? '0 : (r_page_offset + OFFS_W'(1));

        o_push              = i_accept && !ignore;
        o_desc.open         = open;
        o_desc.cmd          = i_cfg.write_command;
        o_desc.addr         = addr;
        o_desc.len_less_one = cur_len;
        o_desc.data         = i_image_byte;
        o_desc.close        = close;
        o_desc.check        = n_check;
        o_desc.image_end    = (n_image_offset >= i_cfg.image_size);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_offset <= '0;
            r_page_offset  <= '0;
            r_len_less_one <= '0;
            r_page_address <= '0;
            r_check        <= '0;
        end else if (o_push) begin
            r_image_offset <= n_image_offset;
            r_page_offset  <= n_page_offset;
            r_len_less_one <= n_len_less_one;
            r_page_address <= n_page_address;
            r_check        <= n_check;
        end
    end

endmodule

// File: rtl/core/bpwf_queue.sv
// Short descriptor queue between the front end and the serializer.
module bpwf_queue #(
    parameter int DEPTH = bpwf_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bpwf_pkg::t_desc     i_desc,
    input  logic                i_pop,
    output bpwf_pkg::t_desc     o_head,
    output bpwf_pkg::t_q_status o_status
);
    import bpwf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : (ptr + PTR_W'(1));
    endfunction

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/core/bpwf_back.sv
// Back end: serializes each descriptor into output beats through an output register.
module bpwf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bpwf_pkg::t_desc     i_head,
    input  bpwf_pkg::t_q_status i_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic [2:0]          o_byte_role,
    output logic                o_last_of_run,
    output logic                o_image_end
);
    import bpwf_pkg::*;

    logic [3:0] r_beat;
    logic       r_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic [2:0] r_byte_role, n_byte_role;
    logic       r_last_of_run, n_last_of_run;
    logic       r_image_end, n_image_end;

    logic       load;
    logic [3:0] beat;

    // A run without a page opening starts straight at the data beat.
    assign beat = (r_beat == BEAT_CMD_HI && !i_head.open) ? BEAT_DATA : r_beat;
    assign load = !i_status.empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_byte    = i_head.data;
        n_byte_role   = ROLE_DATA;
        n_last_of_run = 1'b0;
        n_image_end   = 1'b0;
        unique case (beat)
            BEAT_CMD_HI: begin
                n_out_byte  = i_head.cmd[15:8];
                n_byte_role = ROLE_CMD;
            end
            BEAT_CMD_LO: begin
                n_out_byte  = i_head.cmd[7:0];
                n_byte_role = ROLE_CMD;
            end
            BEAT_ADDR_3: begin
                n_out_byte  = i_head.addr[31:24];
                n_byte_role = ROLE_ADDR;
            end
            BEAT_ADDR_2: begin
                n_out_byte  = i_head.addr[23:16];
                n_byte_role = ROLE_ADDR;
            end
            BEAT_ADDR_1: begin
                n_out_byte  = i_head.addr[15:8];
                n_byte_role = ROLE_ADDR;
            end
            BEAT_ADDR_0: begin
                n_out_byte  = i_head.addr[7:0];
                n_byte_role = ROLE_ADDR;
            end
            BEAT_ADDR_CK: begin
                n_out_byte  = i_head.addr[31:24] ^ i_head.addr[23:16]
                            ^ i_head.addr[15:8] ^ i_head.addr[7:0];
                n_byte_role = ROLE_ADDR;
            end
            BEAT_LEN: begin
                n_out_byte  = i_head.len_less_one;
                n_byte_role = ROLE_LEN;
            end
            BEAT_DATA: begin
                n_out_byte    = i_head.data;
                n_byte_role   = ROLE_DATA;
                n_last_of_run = !i_head.close;
            end
            BEAT_CHECK: begin
                n_out_byte    = i_head.check;
                n_byte_role   = ROLE_CHECK;
                n_last_of_run = 1'b1;
                n_image_end   = i_head.image_end;
            end
            default: begin
                n_out_byte    = i_head.data;
                n_byte_role   = ROLE_DATA;
                n_last_of_run = 1'b1;
            end
        endcase
    end

    assign o_pop = load && n_last_of_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat      <= BEAT_CMD_HI;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_beat <= n_last_of_run ? BEAT_CMD_HI : (beat + 4'd1);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte    <= n_out_byte;
            r_byte_role   <= n_byte_role;
            r_last_of_run <= n_last_of_run;
            r_image_end   <= n_image_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_role   = r_byte_role;
    assign o_last_of_run = r_last_of_run;
    assign o_image_end   = r_image_end;

endmodule

// File: rtl/core/bootloader_page_write_framer.sv
// An item's first beat goes through the descriptor queue and then the output register.
// Throughput: one output beat per cycle from the serializer while the output is not stalled;
// a page-opening byte makes nine beats (ten when it also closes the page), a page-closing
// byte two and any other byte one, so a full page of PAGE_BYTES bytes makes PAGE_BYTES + 9
// beats; input stalls only when the queue is full.
// Reset clears page state, queue and output; registers return to their defaults.
module bootloader_page_write_framer #(
    parameter int PAGE_BYTES  = bpwf_pkg::DEFAULT_PAGE_BYTES,
    parameter int QUEUE_DEPTH = bpwf_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpwf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpwf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_image_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [7:0]                     o_out_byte,
    output logic [2:0]                     o_byte_role,
    output logic                           o_last_of_run,
    output logic                           o_image_end
);
    import bpwf_pkg::*;

    t_cfg      r_cfg;
    logic      push, pop;
    t_desc     desc, head;
    t_q_status q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_size    <= RESET_IMAGE_SIZE;
            r_cfg.start_address <= RESET_START_ADDRESS;
            r_cfg.write_command <= RESET_WRITE_COMMAND;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_SIZE:    r_cfg.image_size    <= i_cfg_data[SIZE_W-1:0];
                CFG_START_ADDRESS: r_cfg.start_address <= i_cfg_data[ADDR_W-1:0];
                CFG_WRITE_COMMAND: r_cfg.write_command <= i_cfg_data[CMD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = q_status.full;

    bpwf_front #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (i_in_valid && !o_in_stall),
        .i_image_byte(i_image_byte),
        .o_push      (push),
        .o_desc      (desc)
    );

    bpwf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_head  (head),
        .o_status(q_status)
    );

    bpwf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_status     (q_status),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_role  (o_byte_role),
        .o_last_of_run(o_last_of_run),
        .o_image_end  (o_image_end)
    );

    // The image end flag only rides on a checksum beat, which always closes its run.
    a_end_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_image_end |-> o_byte_role == ROLE_CHECK && o_last_of_run)
        else $error("image end flag outside a closing checksum beat");

    // Header beats never end a run.
    a_header_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_byte_role == ROLE_CMD || o_byte_role == ROLE_ADDR
        || o_byte_role == ROLE_LEN) |-> !o_last_of_run)
        else $error("run ended on a header beat");

    // A length beat taken by the sink is followed by a data beat.
    a_len_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_byte_role == ROLE_LEN
        |=> o_out_valid && o_byte_role == ROLE_DATA)
        else $error("length beat not followed by data");

    // Nothing is pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !push)
        else $error("descriptor queue overflow");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bootloader page-write framer with a scoreboard class.
module tb;
    import bpwf_pkg::*;

    localparam int                PAGE_LEN       = DEFAULT_PAGE_BYTES;
    localparam int                SETTLE_CYCLES  = 16;
    localparam int                WATCHDOG_LIMIT = 1000;
    localparam int                ITEM_TARGET    = 350;
    localparam logic [SIZE_W-1:0] MAX_IMAGE      = 21'd1048576;

    typedef struct packed {
        logic [7:0] value;
        logic [2:0] role;
        logic       last;
        logic       closes_image;
    } t_beat;

    // Tracks the framing state and holds the beats still owed by the block.
    class page_stream_check;
        logic [SIZE_W-1:0] image_size    = RESET_IMAGE_SIZE;
        logic [ADDR_W-1:0] start_address = RESET_START_ADDRESS;
        logic [CMD_W-1:0]  write_command = RESET_WRITE_COMMAND;
        logic [SIZE_W-1:0] consumed      = '0;
        logic [OFFS_W-1:0] page_fill     = '0;
        logic [7:0]        len_less_one  = '0;
        logic [ADDR_W-1:0] page_addr     = '0;
        logic [7:0]        page_check    = '0;
        t_beat             due_beats[$];
        int                errors        = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_IMAGE_SIZE:    image_size    = data[SIZE_W-1:0];
                CFG_START_ADDRESS: start_address = data[ADDR_W-1:0];
                CFG_WRITE_COMMAND: write_command = data[CMD_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_beat(logic [7:0] value, logic [2:0] role, logic closes);
            t_beat b;
            b.value        = value;
            b.role         = role;
            b.last         = 1'b0;
            b.closes_image = closes;
            due_beats.push_back(b);
        endfunction

        // Returns how many beats the byte causes; zero when the block drops it.
        function int take_image_byte(logic [7:0] data);
            logic [SIZE_W-1:0] left;
            logic [8:0]        span;
            t_beat             tail;
            int                first;
            first = due_beats.size();
            if (page_fill == '0) begin
                if (consumed >= image_size) return 0;
                if (consumed == '0) page_addr = start_address;
                left = image_size - consumed;
                span = (left > PAGE_LEN) ? 9'(PAGE_LEN) : left[8:0];
                len_less_one = 8'(span - 9'd1);
                add_beat(write_command[15:8], ROLE_CMD, 1'b0);
                add_beat(write_command[7:0], ROLE_CMD, 1'b0);
                add_beat(page_addr[31:24], ROLE_ADDR, 1'b0);
                add_beat(page_addr[23:16], ROLE_ADDR, 1'b0);
                add_beat(page_addr[15:8], ROLE_ADDR, 1'b0);
                add_beat(page_addr[7:0], ROLE_ADDR, 1'b0);
                add_beat(page_addr[31:24] ^ page_addr[23:16] ^ page_addr[15:8]
                         ^ page_addr[7:0], ROLE_ADDR, 1'b0);
                add_beat(len_less_one, ROLE_LEN, 1'b0);
                page_check = len_less_one;
            end
            add_beat(data, ROLE_DATA, 1'b0);
            page_check = page_check ^ data;
            consumed   = consumed + SIZE_W'(1);
            // The page keeps the length it opened with, whatever the size register says now.
            if (page_fill >= {1'b0, len_less_one}) begin
                add_beat(page_check, ROLE_CHECK, consumed >= image_size);
                page_addr = page_addr + {24'd0, len_less_one} + 32'd1;
                page_fill = '0;
            end else begin
                page_fill = page_fill + OFFS_W'(1);
            end
            tail      = due_beats.pop_back();
            tail.last = 1'b1;
            due_beats.push_back(tail);
            return due_beats.size() - first;
        endfunction

        function void match_beat(logic [7:0] value, logic [2:0] role, logic last,
                                 logic closes);
            t_beat want;
            if (due_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat: out_byte %h byte_role %0d last_of_run %b image_end %b",
                         $time, value, role, last, closes);
                return;
            end
            want = due_beats.pop_front();
            if (value !== want.value) begin
                errors++;
                $display("%0t: out_byte expected %h, got %h", $time, want.value, value);
            end
            if (role !== want.role) begin
                errors++;
                $display("%0t: byte_role expected %0d, got %0d", $time, want.role, role);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last_of_run expected %b, got %b", $time, want.last, last);
            end
            if (closes !== want.closes_image) begin
                errors++;
                $display("%0t: image_end expected %b, got %b", $time, want.closes_image, closes);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_image_byte;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [7:0]           o_out_byte;
    logic [2:0]           o_byte_role;
    logic                 o_last_of_run;
    logic                 o_image_end;

    page_stream_check frames;
    int               framed_items = 0;
    int               idle_cycles  = 0;
    bit               calm_in      = 1'b0;
    bit               calm_out     = 1'b0;

    bootloader_page_write_framer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_image_byte  (i_image_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_role   (o_byte_role),
        .o_last_of_run (o_last_of_run),
        .o_image_end   (o_image_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pause_len(bit calm);
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        frames.set_reg(idx, data);
    endtask

    task automatic program_regs(input logic [SIZE_W-1:0] size, input logic [ADDR_W-1:0] addr,
                                input logic [CMD_W-1:0] cmd);
        write_reg(CFG_IMAGE_SIZE, CFG_W'(size));
        write_reg(CFG_START_ADDRESS, addr);
        write_reg(CFG_WRITE_COMMAND, CFG_W'(cmd));
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] data);
        int gap;
        gap = pause_len(calm_in);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_image_byte <= data;
        do @(posedge i_clk); while (o_in_stall);
        if (frames.take_image_byte(data) > 0) framed_items++;
    endtask

    // The extra cycles leave the block idle before the registers change.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (frames.due_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            frames.match_beat(o_out_byte, o_byte_role, o_last_of_run, o_image_end);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin : out_side
        int hold;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = pause_len(calm_out);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin : in_side
        int                pick;
        int                count;
        int                left;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        frames = new();
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_IMAGE_SIZE;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_image_byte <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With a zero image size every byte is dropped.
        program_regs('0, 32'hFFFF_FFFF, 16'hFFFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        settle();

        // One-byte image at the top of the address space; the next page address wraps.
        program_regs(21'd1, 32'hFFFF_FFFF, 16'h8001);
        push_byte(8'hA5);
        push_byte(8'h5A);
        settle();

        // The image grows by a two-byte page; the start address no longer applies.
        program_regs(21'd3, 32'h0000_0000, 16'h0000);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        settle();

        // A five-byte page that sees the size raised halfway through.
        program_regs(21'd8, 32'h1234_5678, 16'h2A55);
        push_byte(8'h7F);
        push_byte(8'h01);
        settle();
        program_regs(21'd12, 32'hFFFF_FFFF, 16'hD5AA);
        push_byte(8'hC3);
        push_byte(8'h3C);
        push_byte(8'h10);
        push_byte(8'h55);
        settle();

        // Largest size, then a size below what was already sent, both in mid-page.
        program_regs(MAX_IMAGE, 32'h0000_0000, 16'h00FF);
        push_byte(8'hAA);
        settle();
        program_regs(21'd2, 32'h8000_0000, 16'hFF00);
        push_byte(8'h0F);
        push_byte(8'hF0);
        push_byte(8'h99);
        settle();

        while (framed_items < ITEM_TARGET) begin
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       size = frames.consumed;
                1:       size = MAX_IMAGE;
                2:       size = SIZE_W'($urandom_range(0, frames.consumed));
                3:       size = frames.consumed + SIZE_W'($urandom_range(200, 300));
                default: size = frames.consumed + SIZE_W'($urandom_range(1, 40));
            endcase
            addr = ($urandom_range(0, 4) == 0) ? '1 : ADDR_W'($urandom());
            program_regs(size, addr, CMD_W'($urandom_range(0, 65535)));
            left = (size > frames.consumed) ? int'(size - frames.consumed) : 0;
            if (pick == 1) begin
                count = $urandom_range(1, 270);
            end else if (left == 0) begin
                count = $urandom_range(1, 3);
            end else if ($urandom_range(0, 3) == 0) begin
                count = $urandom_range(1, left);
            end else begin
                count = left + $urandom_range(0, 2);
            end
            if (count > ITEM_TARGET - framed_items) begin
                count = ITEM_TARGET - framed_items;
            end
            for (int k = 0; k < count; k++) begin
                if ($urandom_range(0, 39) == 0) begin
                    // Hold the sender back until the block has caught up.
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (frames.due_beats.size() != 0);
                end
                push_byte(8'($urandom_range(0, 255)));
            end
            settle();
        end

        if (frames.errors == 0 && frames.due_beats.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
